/* rtl/cca_pkg.sv */
// ---------------------------------------------------------------------------
// cca_pkg
// Shared types, constants and lookups for the pipe color code expander.
// ---------------------------------------------------------------------------
package cca_pkg;

  localparam int unsigned RunMax = 7;  // longest run of bytes for one request
  localparam int unsigned CntW   = 3;  // holds 0 .. RunMax

  localparam logic [7:0] BarChar  = 8'h7C;
  localparam logic [7:0] EscChar  = 8'h1B;
  localparam logic [7:0] LbrChar  = 8'h5B;
  localparam logic [7:0] SemiChar = 8'h3B;
  localparam logic [7:0] MChar    = 8'h6D;
  localparam logic [7:0] ZeroChar = 8'h30;
  localparam logic [7:0] NineChar = 8'h39;
  localparam logic [7:0] FgChar   = 8'h33;  // '3' of the foreground "3x"

  // intensity flag per color code, codes 8..15 are bold
  localparam logic [15:0] BoldMask = 16'hFF00;
  localparam logic [2:0] HueTab [16] = '{
    3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7,
    3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7
  };

  typedef enum logic [2:0] {
    PhIdle  = 3'b001,
    PhBar   = 3'b010,
    PhDigit = 3'b100
  } phase_e;

  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;    // bytes[0] goes out first
    logic [CntW-1:0]        cnt;
    logic                   msg_end;
  } run_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ZeroChar) && (b <= NineChar);
  endfunction

endpackage

/* rtl/pipe_color_code_to_ansi.sv */
// ---------------------------------------------------------------------------
// pipe_color_code_to_ansi
// Expands pipe color codes in a byte stream into ANSI escape sequences.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries message bytes (tdata) with tlast on the final byte.
//   Master stream carries the translated bytes; tuser marks the last byte
//   produced by one input request, tlast the final byte of the message.
//   "|01".."|15" become ESC [ b ; 3 h m, "||" gives one bar, broken codes
//   come back literally, and a pending bar/digit is flushed at tlast.
//   cfg_we_i/cfg_data_i set passthrough (echo every byte); write it only
//   while the block is idle.
// Path: an input request is captured in the input register, then decoded
//   into the result register, which presents its first output byte.
// Throughput: one input request per cycle while each yields at most one
//   byte and the output is not stalled; a longer run occupies the result
//   register until all its bytes are taken, holding the next request in the
//   input register. Held-back bar or digit requests produce nothing.
// Reset: clears both registers' valid state, the escape phase (no bar
//   pending) and passthrough. The held digit has no reset.
// Stall: when m_axis_tready_i is low the current byte holds; the next
//   byte-making request waits in the input register; s_axis_tready_o drops.
// ---------------------------------------------------------------------------
module pipe_color_code_to_ansi import cca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,       // passthrough
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] out_run_last
  output logic       m_axis_tlast_o    // out_message_end
);

  logic       pass_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  phase_e     phase_q, phase_d;
  logic [7:0] held_q;
  logic       held_we;
  run_t       dec_run;
  logic       load_ready, consume, load, s_accept;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 1'b0;
    end else if (cfg_we_i) begin
      pass_q <= cfg_data_i;
    end
  end

  // a request leaves the input register when its run fits in the result
  // register, or at once when it produces no bytes
  assign consume         = in_valid_q && ((dec_run.cnt == '0) || load_ready);
  assign load            = consume && (dec_run.cnt != '0);
  assign s_axis_tready_o = !in_valid_q || consume;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // escape phase and the held first digit of a code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
    end else if (consume) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && held_we) begin
      held_q <= in_byte_q;
    end
  end

  cca_decode u_decode (
    .pass_i    (pass_q),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .phase_i   (phase_q),
    .held_i    (held_q),
    .run_o     (dec_run),
    .phase_o   (phase_d),
    .held_we_o (held_we)
  );

  cca_serializer u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .run_i           (dec_run),
    .load_ready_o    (load_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* rtl/cca_decode.sv */
// ---------------------------------------------------------------------------
// cca_decode
// Turns one registered byte plus the escape phase into a run of output bytes
// and the next phase.
// ---------------------------------------------------------------------------
module cca_decode import cca_pkg::*; (
  input  logic       pass_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  phase_e     phase_i,
  input  logic [7:0] held_i,
  output run_t       run_o,
  output phase_e     phase_o,
  output logic       held_we_o
);

  logic [RunMax-1:0][7:0] main;
  logic [CntW-1:0]        n0;
  phase_e                 mid;
  logic                   code_ok;
  logic [3:0]             hd, cd, idx;
  logic                   flush1, flush2;
  logic [7:0]             held_nx;

  assign hd      = held_i[3:0];
  assign cd      = byte_i[3:0];
  assign code_ok = ((hd == 4'd0) && (cd != 4'd0)) || ((hd == 4'd1) && (cd <= 4'd5));
  assign idx     = (hd == 4'd0) ? cd : cd + 4'd10;

  always_comb begin
    main      = '0;
    n0        = '0;
    mid       = PhIdle;
    held_we_o = 1'b0;
    if (pass_i) begin
      main[0] = byte_i;
      n0      = CntW'(1);
      mid     = phase_i;
    end else begin
      case (phase_i)
        PhDigit: begin
          if (!is_digit(byte_i)) begin
            main[0] = BarChar;
            main[1] = held_i;
            if (byte_i == BarChar) begin
              n0  = CntW'(2);
              mid = PhBar;
            end else begin
              main[2] = byte_i;
              n0      = CntW'(3);
            end
          end else if (code_ok) begin
            main[0] = EscChar;
            main[1] = LbrChar;
            main[2] = ZeroChar + {7'd0, BoldMask[idx]};
            main[3] = SemiChar;
            main[4] = FgChar;
            main[5] = ZeroChar + {5'd0, HueTab[idx]};
            main[6] = MChar;
            n0      = CntW'(7);
          end else begin
            main[0] = BarChar;
            main[1] = held_i;
            main[2] = byte_i;
            n0      = CntW'(3);
          end
        end
        PhBar: begin
          if (byte_i == BarChar) begin
            main[0] = BarChar;
            n0      = CntW'(1);
          end else if (!is_digit(byte_i)) begin
            main[0] = BarChar;
            main[1] = byte_i;
            n0      = CntW'(2);
          end else begin
            held_we_o = 1'b1;
            mid       = PhDigit;
          end
        end
        default: begin
          if (byte_i == BarChar) begin
            mid = PhBar;
          end else begin
            main[0] = byte_i;
            n0      = CntW'(1);
          end
        end
      endcase
    end
  end

  // end of message flushes a pending bar, and digit if held
  assign flush1  = !pass_i && last_i && (mid != PhIdle);
  assign flush2  = !pass_i && last_i && (mid == PhDigit);
  assign held_nx = held_we_o ? byte_i : held_i;
  assign phase_o = last_i ? PhIdle : mid;

  always_comb begin
    run_o.bytes = main;
    for (int i = 0; i < RunMax; i++) begin
      if (flush1 && (CntW'(i) == n0)) begin
        run_o.bytes[i] = BarChar;
      end
      if (flush2 && (CntW'(i) == n0 + CntW'(1))) begin
        run_o.bytes[i] = held_nx;
      end
    end
    run_o.cnt     = n0 + CntW'(flush1) + CntW'(flush2);
    run_o.msg_end = last_i;
  end

endmodule

/* rtl/cca_serializer.sv */
// ---------------------------------------------------------------------------
// cca_serializer
// Result register: holds one run and shifts it out one byte per transfer.
// ---------------------------------------------------------------------------
module cca_serializer import cca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  run_t       run_i,
  output logic       load_ready_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tuser_o,
  output logic       m_axis_tlast_o
);

  logic [RunMax-1:0][7:0] bytes_q;
  logic [CntW-1:0]        rem_q;
  logic                   end_q;
  logic                   take, tail;

  assign tail         = (rem_q == CntW'(1));
  assign take         = m_axis_tvalid_o && m_axis_tready_i;
  assign load_ready_o = (rem_q == '0) || (take && tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      end_q <= 1'b0;
    end else if (load_i) begin
      rem_q <= run_i.cnt;
      end_q <= run_i.msg_end;
    end else if (take) begin
      rem_q <= rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= run_i.bytes;
    end else if (take) begin
      for (int i = 0; i < RunMax - 1; i++) begin
        bytes_q[i] <= bytes_q[i+1];
      end
    end
  end

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tdata_o  = bytes_q[0];
  assign m_axis_tuser_o  = tail;
  assign m_axis_tlast_o  = tail && end_q;

endmodule

/* rtl/cca_checker.sv */
// ---------------------------------------------------------------------------
// cca_checker
// Port-level checks for the pipe color code expander, bound to the top.
// ---------------------------------------------------------------------------
module cca_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // stalled output holds its byte and flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled output changed");

  // message end is always the tail of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("tlast without run end");

  // bytes within a run follow without a bubble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tuser_o |=> m_axis_tvalid_o)
    else $error("bubble inside a run");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid out of reset");

endmodule

bind pipe_color_code_to_ansi cca_checker u_cca_checker (.*);
